[hw/rtl/rcsv_pkg.sv]
package rcsv_pkg;

	// Fixed field widths of the ports.
	localparam int VALUE_W = 14;
	localparam int OUT_W   = 16;

	// Default sizing of the stores.
	localparam int VALUE_RANGE_DEF = 16384;
	localparam int BLOCK_SIZE_DEF  = 128;
	localparam int COUNT_BITS_DEF  = 16;

	// Controls of the shared saturating accumulator.
	typedef struct packed {
		logic clr;
		logic add;
	} acc_ctrl_t;

endpackage

[hw/rtl/rcsv_ram.sv]
module rcsv_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[hw/rtl/rcsv_sat_acc.sv]
module rcsv_sat_acc
	import rcsv_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  acc_ctrl_t             ctrl,
	input  logic [COUNT_BITS-1:0] addend,
	output logic [COUNT_BITS-1:0] sum
);

	logic [COUNT_BITS-1:0] sum_q;
	logic [COUNT_BITS:0]   wide_sum;

	// One adder with a carry check; the running sum sticks at all ones.
	assign wide_sum = {1'b0, sum_q} + {1'b0, addend};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clr) begin
			sum_q <= '0;
		end else if (ctrl.add) begin
			sum_q <= wide_sum[COUNT_BITS] ? '1 : wide_sum[COUNT_BITS-1:0];
		end
	end

	assign sum = sum_q;

endmodule

[hw/rtl/running_count_of_smaller_values_unit.sv]
// For each value it receives, this unit returns how many earlier values of the
// current sequence were strictly smaller, saturating at all ones. VALUE_RANGE
// and BLOCK_SIZE are powers of two; a value is reduced modulo VALUE_RANGE. When
// an item's block is touched for the first time since reset or the last
// new_sequence, its row (BLOCK_SIZE entries, or VALUE_RANGE if smaller) is
// first zeroed one entry per cycle. A single saturating adder then walks the
// block totals and then the histogram row, one memory read per cycle. The unit
// takes one item at a time; a finished result waits in an output register while
// the next item is taken in. There is no clearing pass after reset.
module running_count_of_smaller_values_unit
	import rcsv_pkg::*;
#(
	parameter int VALUE_RANGE = VALUE_RANGE_DEF,
	parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [VALUE_W-1:0] value,
	input  logic               new_sequence,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [OUT_W-1:0]   smaller_count
);

	localparam int IDX_W      = $clog2(VALUE_RANGE);
	localparam int ROW_LEN    = (BLOCK_SIZE < VALUE_RANGE) ? BLOCK_SIZE : VALUE_RANGE;
	localparam int OFF_W      = $clog2(ROW_LEN);
	localparam int NUM_BLOCKS = (VALUE_RANGE + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int BI_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int EXT_W      = IDX_W + VALUE_W;
	localparam int CLAMP_W    = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CLEAR   = 3'd1;
	localparam logic [2:0] S_SUMBLK  = 3'd2;
	localparam logic [2:0] S_SUMHIST = 3'd3;
	localparam logic [2:0] S_UPDRD   = 3'd4;
	localparam logic [2:0] S_UPDWR   = 3'd5;
	localparam logic [2:0] S_DONE    = 3'd6;

	logic [2:0]            state_q;
	logic [IDX_W-1:0]      v_q;
	logic [BI_W-1:0]       blk_q;
	logic [BI_W-1:0]       idx_q;
	logic [OFF_W-1:0]      off_q;
	logic [NUM_BLOCKS-1:0] blk_valid_q;
	logic                  pend_tot_q;
	logic                  pend_hist_q;
	logic                  result_valid_q;
	logic [OUT_W-1:0]      smaller_count_q;

	logic [EXT_W-1:0]      value_ext;
	logic [IDX_W-1:0]      v_in;
	logic [BI_W-1:0]       blk_in;
	logic [OFF_W-1:0]      v_off;
	logic                  accept;
	logic                  out_free;
	logic                  blk_more;
	logic                  hist_more;
	logic [IDX_W-1:0]      row_addr;

	logic                  hist_we;
	logic [IDX_W-1:0]      hist_raddr;
	logic [COUNT_BITS-1:0] hist_wdata;
	logic [COUNT_BITS-1:0] hist_rdata;
	logic                  tot_we;
	logic [BI_W-1:0]       tot_raddr;
	logic [COUNT_BITS-1:0] tot_wdata;
	logic [COUNT_BITS-1:0] tot_rdata;

	acc_ctrl_t             acc_ctrl;
	logic [COUNT_BITS-1:0] acc_addend;
	logic [COUNT_BITS-1:0] acc_sum;
	logic [CLAMP_W-1:0]    sum_ext;
	logic [OUT_W-1:0]      sum_clamped;

	// Reduce the value to the histogram range and split it into block and offset.
	assign value_ext = EXT_W'(value);
	assign v_in      = value_ext[IDX_W-1:0];
	assign blk_in    = BI_W'(v_in >> OFF_W);
	assign v_off     = v_q[OFF_W-1:0];
	assign row_addr  = IDX_W'(off_q) | (IDX_W'(blk_q) << OFF_W);

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !result_valid_q || result_ready;
	assign blk_more   = (idx_q < blk_q);
	assign hist_more  = (off_q < v_off);

	// Sequencer: zero a fresh row, walk block totals, walk the row, then update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			blk_valid_q <= '0;
			idx_q       <= '0;
			off_q       <= '0;
			pend_tot_q  <= 1'b0;
			pend_hist_q <= 1'b0;
		end else begin
			pend_tot_q  <= (state_q == S_SUMBLK) && blk_more && blk_valid_q[idx_q];
			pend_hist_q <= (state_q == S_SUMHIST) && hist_more;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						off_q <= '0;
						if (new_sequence) begin
							blk_valid_q <= '0;
							state_q     <= S_CLEAR;
						end else if (!blk_valid_q[blk_in]) begin
							state_q <= S_CLEAR;
						end else begin
							state_q <= S_SUMBLK;
						end
					end
				end
				S_CLEAR: begin
					if (off_q == OFF_W'(ROW_LEN - 1)) begin
						off_q              <= '0;
						blk_valid_q[blk_q] <= 1'b1;
						state_q            <= S_SUMBLK;
					end else begin
						off_q <= off_q + 1'b1;
					end
				end
				S_SUMBLK: begin
					if (blk_more) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_SUMHIST;
					end
				end
				S_SUMHIST: begin
					if (hist_more) begin
						off_q <= off_q + 1'b1;
					end else begin
						state_q <= S_UPDRD;
					end
				end
				S_UPDRD: begin
					state_q <= S_UPDWR;
				end
				S_UPDWR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Latch the item's value and block at the input transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q   <= v_in;
			blk_q <= blk_in;
		end
	end

	// Memory port steering.
	always_comb begin
		hist_raddr = (state_q == S_SUMHIST) ? row_addr : v_q;
		tot_raddr  = (state_q == S_SUMBLK) ? idx_q : blk_q;
		hist_we    = (state_q == S_CLEAR) || (state_q == S_UPDWR);
		tot_we     = hist_we;
		if (state_q == S_UPDWR) begin
			hist_wdata = (hist_rdata == '1) ? hist_rdata : hist_rdata + 1'b1;
			tot_wdata  = (tot_rdata == '1) ? tot_rdata : tot_rdata + 1'b1;
		end else begin
			hist_wdata = '0;
			tot_wdata  = '0;
		end
	end

	rcsv_ram #(
		.DEPTH (VALUE_RANGE),
		.WIDTH (COUNT_BITS),
		.AW    (IDX_W)
	) u_hist (
		.clk     (clk),
		.wr_en   (hist_we),
		.wr_addr ((state_q == S_CLEAR) ? row_addr : v_q),
		.wr_data (hist_wdata),
		.rd_addr (hist_raddr),
		.rd_data (hist_rdata)
	);

	rcsv_ram #(
		.DEPTH (NUM_BLOCKS),
		.WIDTH (COUNT_BITS),
		.AW    (BI_W)
	) u_totals (
		.clk     (clk),
		.wr_en   (tot_we),
		.wr_addr (blk_q),
		.wr_data (tot_wdata),
		.rd_addr (tot_raddr),
		.rd_data (tot_rdata)
	);

	// Feed returning read data into the shared accumulator.
	always_comb begin
		acc_ctrl.clr = accept;
		acc_ctrl.add = pend_tot_q || pend_hist_q;
		acc_addend   = pend_tot_q ? tot_rdata : hist_rdata;
	end

	rcsv_sat_acc #(
		.COUNT_BITS (COUNT_BITS)
	) u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.addend (acc_addend),
		.sum    (acc_sum)
	);

	// Clamp the count to the output width.
	assign sum_ext     = CLAMP_W'(acc_sum);
	assign sum_clamped = (sum_ext > CLAMP_W'({OUT_W{1'b1}})) ? '1 : sum_ext[OUT_W-1:0];

	// Output register holds the result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			smaller_count_q <= sum_clamped;
		end
	end

	assign result_valid  = result_valid_q;
	assign smaller_count = smaller_count_q;

endmodule

[verif/smaller_count_checker.sv]
module smaller_count_checker
	import rcsv_pkg::*;
#(
	parameter int VALUE_RANGE = VALUE_RANGE_DEF,
	parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_ready,
	input  logic [VALUE_W-1:0] value,
	input  logic               new_sequence,
	input  logic               result_valid,
	input  logic               result_ready,
	input  logic [OUT_W-1:0]   smaller_count,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BLOCKS = (VALUE_RANGE + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
	localparam longint unsigned OUT_MAX = (64'd1 << OUT_W) - 64'd1;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [OUT_W-1:0]   count;
	} rank_entry_t;

	// Shadow copies of the occurrence histogram and the per-block totals.
	logic [COUNT_BITS-1:0] occurrences [VALUE_RANGE];
	logic [COUNT_BITS-1:0] block_sums [NUM_BLOCKS];

	rank_entry_t expected_counts [$];
	int fail_count = 0;

	function automatic void clear_counts();
		for (int i = 0; i < VALUE_RANGE; i++)
			occurrences[i] = '0;
		for (int i = 0; i < NUM_BLOCKS; i++)
			block_sums[i] = '0;
	endfunction

	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
		if (longint'(c) >= COUNT_MAX)
			return c;
		return c + 1'b1;
	endfunction

	// Records the value and returns how many earlier values of the sequence lie below it.
	function automatic logic [OUT_W-1:0] predict_smaller_count(input logic [VALUE_W-1:0] v_in,
			input logic ns);
		int unsigned v;
		int unsigned blk;
		int unsigned base;
		longint unsigned sum;
		v = int'(v_in) % VALUE_RANGE;
		blk = v / BLOCK_SIZE;
		base = blk * BLOCK_SIZE;
		sum = 0;
		if (ns)
			clear_counts();
		occurrences[v] = bump(occurrences[v]);
		block_sums[blk] = bump(block_sums[blk]);
		for (int unsigned i = 0; i < blk; i++) begin
			sum += block_sums[i];
			if (sum > COUNT_MAX)
				sum = COUNT_MAX;
		end
		for (int unsigned i = base; i < v; i++) begin
			sum += occurrences[i];
			if (sum > COUNT_MAX)
				sum = COUNT_MAX;
		end
		if (sum > OUT_MAX)
			sum = OUT_MAX;
		return sum[OUT_W-1:0];
	endfunction

	// Watch both channels: compare each result transfer, then predict each item transfer.
	always @(posedge clk or negedge arst_n) begin
		rank_entry_t head;
		rank_entry_t fresh;
		if (!arst_n) begin
			clear_counts();
			expected_counts.delete();
			errors <= fail_count;
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_counts.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result transfer, smaller_count %0d",
							$realtime, smaller_count);
				end else begin
					head = expected_counts.pop_front();
					if (smaller_count !== head.count) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: value %0d: smaller_count expected %0d, got %0d",
								$realtime, head.value, head.count, smaller_count);
					end
				end
			end
			if (item_valid && item_ready) begin
				fresh.value = value;
				fresh.count = predict_smaller_count(value, new_sequence);
				expected_counts.push_back(fresh);
			end
			errors <= fail_count;
			pending <= expected_counts.size();
		end
	end

endmodule

[verif/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rcsv_pkg::*;

	localparam int CYCLE_LIMIT     = 1_500_000;
	localparam int DRAIN_CYCLES    = 400;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int NUM_BLOCKS      = VALUE_RANGE_DEF / BLOCK_SIZE_DEF;
	localparam int VALUE_TOP       = VALUE_RANGE_DEF - 1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic [VALUE_W-1:0] value = '0;
	logic               new_sequence = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [OUT_W-1:0]   smaller_count;

	int errors;
	int pending;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Sequence shaping for the random part.
	int seq_left = 0;
	int hot_blocks [4];
	logic [VALUE_W-1:0] seq_values [$];

	running_count_of_smaller_values_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.value        (value),
		.new_sequence (new_sequence),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.smaller_count(smaller_count)
	);

	smaller_count_checker i_rank_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.value        (value),
		.new_sequence (new_sequence),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.smaller_count(smaller_count),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random with the current stall rate.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Present one item after an optional random gap and hold it until the transfer.
	task automatic send_item(input logic [VALUE_W-1:0] v, input logic ns);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		item_valid <= 1'b1;
		value <= v;
		new_sequence <= ns;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	// Drop valid and hold off until every expected count has come back.
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed sequences: a few hot blocks, repeated values and block edges.
	task automatic send_random(input int count);
		int sel;
		int v;
		logic ns;
		for (int n = 0; n < count; n++) begin
			ns = 1'b0;
			if (seq_left == 0) begin
				seq_left = $urandom_range(60, 3);
				ns = 1'b1;
				seq_values.delete();
				foreach (hot_blocks[k])
					hot_blocks[k] = $urandom_range(NUM_BLOCKS - 1);
			end else if ($urandom_range(99) < 3) begin
				ns = 1'b1;
				seq_values.delete();
			end
			seq_left--;
			sel = $urandom_range(99);
			if (sel < 40) begin
				v = hot_blocks[$urandom_range(3)] * BLOCK_SIZE_DEF
					+ $urandom_range(BLOCK_SIZE_DEF - 1);
			end else if (sel < 60 && seq_values.size() > 0) begin
				v = seq_values[$urandom_range(seq_values.size() - 1)];
			end else if (sel < 72) begin
				case ($urandom_range(3))
					0: v = 0;
					1: v = VALUE_TOP;
					2: v = $urandom_range(NUM_BLOCKS - 1) * BLOCK_SIZE_DEF;
					default: v = $urandom_range(NUM_BLOCKS - 1) * BLOCK_SIZE_DEF
						+ BLOCK_SIZE_DEF - 1;
				endcase
			end else begin
				v = $urandom_range(VALUE_TOP);
			end
			seq_values.push_back(v[VALUE_W-1:0]);
			send_item(v[VALUE_W-1:0], ns);
		end
	endtask

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: stores empty, extremes, block edges, ties and fresh sequences.
		send_item(14'd0, 1'b1);
		send_item(14'd0, 1'b0);
		send_item(14'h3FFF, 1'b0);
		send_item(14'h3FFF, 1'b0);
		send_item(14'd1, 1'b0);
		send_item(14'd127, 1'b0);
		send_item(14'd128, 1'b0);
		send_item(14'd129, 1'b0);
		send_item(14'd255, 1'b0);
		send_item(14'd256, 1'b0);
		send_item(14'h2AAA, 1'b0);
		send_item(14'h1555, 1'b0);
		send_item(14'd8191, 1'b0);
		send_item(14'd8192, 1'b0);
		send_item(14'd16256, 1'b0);
		send_item(14'd16255, 1'b0);
		send_item(14'd100, 1'b0);
		send_item(14'd0, 1'b0);
		send_item(14'h3FFF, 1'b1);
		send_item(14'h3FFF, 1'b0);
		send_item(14'd0, 1'b1);
		send_item(14'd12345, 1'b1);
		send_item(14'd12345, 1'b0);
		send_item(14'd12346, 1'b0);

		// Random part over the idling phases, drained between phases.
		send_random(ITEMS_PER_PHASE);
		wait_drained();
		send_idle_pct = 61;
		recv_stall_pct = 0;
		send_random(ITEMS_PER_PHASE);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 61;
		send_random(ITEMS_PER_PHASE);
		wait_drained();
		send_idle_pct = 7;
		recv_stall_pct = 7;
		send_random(ITEMS_PER_PHASE);

		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
